### rtl/tsw_pkg.sv
// tsw_pkg: shared codes for the wrap-mode texture sampler
// item function codes and configuration register indexes
// no dependencies
package tsw_pkg;

  localparam logic [1:0] FUNC_LOAD     = 2'd0;
  localparam logic [1:0] FUNC_NEAREST  = 2'd1;
  localparam logic [1:0] FUNC_BILINEAR = 2'd2;

  localparam logic [1:0] REG_TEX_WIDTH  = 2'd0;
  localparam logic [1:0] REG_TEX_HEIGHT = 2'd1;

  localparam int SIZE_W  = 9;
  localparam int TEXEL_W = 24;

endpackage

### rtl/texture_sampler_wrap_bilinear_top.sv
// texture_sampler_wrap_bilinear_top: wrap-mode nearest/bilinear texture sampler
// depends on tsw_pkg, tsw_fifo, tsw_front, tsw_back (which holds tsw_ram)
//
// channel  | direction | handshake           | payload
// in_      | input     | in_tvalid/in_tready | tuser func, tdata index/rgb/s/t
// out_     | output    | out_tvalid/out_tready | tdata red/green/blue
// cfg_     | input     | cfg_we              | cfg_index, cfg_wdata
//
// loads and nearest samples take one texel memory op, bilinear samples four reads
// (one per texel on the single-port memory); a sample reaches out_tvalid through the
// front stages, op queue, ram read and product registers and the output buffer
// front and back stall on their own through a 4-item op queue; output buffer holds 4
// synchronous active-low reset clears control state and sets both sizes to 1
module texture_sampler_wrap_bilinear_top #(
  parameter int TEXEL_DEPTH     = 65536,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,   // func
  input  logic [103:0] in_tdata,   // texel_index, load_red, load_green, load_blue,
                                   // coord_s, coord_t
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata,  // color_red, color_green, color_blue
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [8:0]   cfg_wdata
);
  import tsw_pkg::*;

  localparam int F  = COORD_FRAC_BITS;
  localparam int AW = (TEXEL_DEPTH > 1) ? $clog2(TEXEL_DEPTH) : 1;
  localparam int WW = 2 * F + 1;
  localparam int QW = 2 + 4 * AW + 4 * WW + TEXEL_W;
  localparam int OQ_DEPTH = 4;

  logic [SIZE_W-1:0] tex_width_r, tex_height_r, size_w, size_h;
  logic              q_push, q_full, q_empty, q_pop;
  logic [QW-1:0]     q_data, q_head;
  logic              res_push, res_empty, res_full, res_pop;
  logic [TEXEL_W-1:0] res_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= SIZE_W'(1);
      tex_height_r <= SIZE_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEX_WIDTH:  tex_width_r  <= cfg_wdata;
        REG_TEX_HEIGHT: tex_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a size of zero acts as one
  assign size_w = (tex_width_r  == '0) ? SIZE_W'(1) : tex_width_r;
  assign size_h = (tex_height_r == '0) ? SIZE_W'(1) : tex_height_r;

  tsw_front #(
    .TEXEL_DEPTH(TEXEL_DEPTH),
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .QW(QW)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .size_w  (size_w),
    .size_h  (size_h),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .in_func (in_tuser),
    .in_index(in_tdata[15:0]),
    .in_rgb  (in_tdata[39:16]),
    .in_fs   (in_tdata[40 +: F]),
    .in_ft   (in_tdata[72 +: F]),
    .q_push  (q_push),
    .q_data  (q_data),
    .q_full  (q_full)
  );

  tsw_fifo #(
    .WIDTH(QW),
    .DEPTH(4)
  ) u_opq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_data),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  tsw_back #(
    .TEXEL_DEPTH(TEXEL_DEPTH),
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .QW(QW),
    .OQ_DEPTH(OQ_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_head  (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .res_push(res_push),
    .res_data(res_data),
    .res_pop (res_pop)
  );

  tsw_fifo #(
    .WIDTH(TEXEL_W),
    .DEPTH(OQ_DEPTH)
  ) u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push && !res_full),
    .push_data(res_data),
    .pop      (res_pop),
    .head     (out_tdata),
    .full     (res_full),
    .empty    (res_empty)
  );

  assign out_tvalid = !res_empty;
  assign res_pop    = out_tvalid && out_tready;
endmodule

### rtl/tsw_ram.sv
// tsw_ram: generic single-port ram with registered read
// no dependencies
module tsw_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                    wdata,
  output logic [WIDTH-1:0]                    rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end else begin
      rdata <= mem_r[addr];
    end
  end
endmodule

### rtl/tsw_fifo.sv
// tsw_fifo: small register fifo, head item visible combinationally
// no dependencies
module tsw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]      cnt_r, cnt_nxt;

  assign full  = (cnt_r == (PW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end
endmodule

### rtl/tsw_front.sv
// tsw_front: accepts items, wraps coordinates, builds texel addresses and weights
// depends on tsw_pkg; feeds the op queue read by tsw_back
module tsw_front #(
  parameter int TEXEL_DEPTH     = 65536,
  parameter int COORD_FRAC_BITS = 16,
  parameter int QW              = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tsw_pkg::SIZE_W-1:0]    size_w,
  input  logic [tsw_pkg::SIZE_W-1:0]    size_h,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_func,
  input  logic [15:0]                   in_index,
  input  logic [tsw_pkg::TEXEL_W-1:0]   in_rgb,
  input  logic [COORD_FRAC_BITS-1:0]    in_fs,
  input  logic [COORD_FRAC_BITS-1:0]    in_ft,
  output logic                          q_push,
  output logic [QW-1:0]                 q_data,
  input  logic                          q_full
);
  import tsw_pkg::*;

  localparam int F   = COORD_FRAC_BITS;
  localparam int AW  = (TEXEL_DEPTH > 1) ? $clog2(TEXEL_DEPTH) : 1;
  localparam int WW  = 2 * F + 1;
  localparam int VW  = 2 * SIZE_W;
  localparam int PS  = F + SIZE_W + 1;
  localparam int RCP_V = (2 ** VW) / TEXEL_DEPTH;
  localparam int DC_V  = (TEXEL_DEPTH < (2 ** VW)) ? TEXEL_DEPTH : (2 ** VW);
  localparam logic [VW:0]   RCP  = (VW+1)'(RCP_V);
  localparam logic [VW:0]   DC   = (VW+1)'(DC_V);
  localparam logic [PS-1:0] HALF = PS'(1) << (F - 1);
  localparam logic [F:0]    ONE  = (F+1)'(1) << F;
  localparam logic [WW-1:0] ONE2 = WW'(1) << (2 * F);

  typedef struct packed {
    logic [1:0]              kind;
    logic [3:0][AW-1:0]      addr;
    logic [3:0][WW-1:0]      wt;
    logic [TEXEL_W-1:0]      rgb;
  } qent_t;

  logic adv;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;

  // stage 1: registered item
  logic [1:0]          f1_r;
  logic [15:0]         idx1_r;
  logic [TEXEL_W-1:0]  rgb1_r;
  logic [F-1:0]        fs1_r, ft1_r;
  logic [SIZE_W-1:0]   w1_r, h1_r;
  // stage 2: scaled coordinates
  logic [1:0]          f2_r;
  logic [15:0]         idx2_r;
  logic [TEXEL_W-1:0]  rgb2_r;
  logic [SIZE_W-1:0]   w2_r, h2_r;
  logic [PS-1:0]       ps2_r, pt2_r;
  // stage 3: wrapped indexes and fractions
  logic [1:0]          f3_r;
  logic [15:0]         idx3_r;
  logic [TEXEL_W-1:0]  rgb3_r;
  logic [SIZE_W-1:0]   w3_r, x03_r, x13_r, y03_r, y13_r;
  logic [F-1:0]        a3_r, b3_r;
  logic [SIZE_W:0]     is2, it2;
  logic [SIZE_W-1:0]   x1c, y1c, x0c, y0c;
  // stage 4: weights and row bases
  logic [1:0]          f4_r;
  logic [15:0]         idx4_r;
  logic [TEXEL_W-1:0]  rgb4_r;
  logic [SIZE_W-1:0]   x04_r, x14_r;
  logic [VW-1:0]       row04_r, row14_r;
  logic [3:0][WW-1:0]  wt4_r;
  logic [F:0]          oma, omb;
  // stage 5..7: address reduction
  logic [1:0]          f5_r, f6_r, f7_r;
  logic [TEXEL_W-1:0]  rgb5_r, rgb6_r, rgb7_r;
  logic [3:0][WW-1:0]  wt5_r, wt6_r, wt7_r;
  logic [3:0][VW-1:0]  addr5_r, addr6_r, q6_r, r7_r;
  logic [3:0][VW-1:0]  v5c;
  logic [WW-1:0]       wt0c;
  logic [2*VW:0]       qprod [4];
  logic [2*VW:0]       pprod [4];
  qent_t               ent;

  assign adv      = !(v7_r && q_full);
  assign in_ready = adv;
  assign q_push   = v7_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r} <= '0;
    end else if (adv) begin
      // unused function code is dropped here
      v1_r <= in_valid && (in_func == FUNC_LOAD || in_func == FUNC_NEAREST ||
                           in_func == FUNC_BILINEAR);
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_comb begin
    is2 = ps2_r[F +: SIZE_W+1];
    it2 = pt2_r[F +: SIZE_W+1];
    x1c = (is2 >= {1'b0, w2_r}) ? SIZE_W'(is2 - {1'b0, w2_r}) : is2[SIZE_W-1:0];
    y1c = (it2 >= {1'b0, h2_r}) ? SIZE_W'(it2 - {1'b0, h2_r}) : it2[SIZE_W-1:0];
    x0c = (x1c == '0) ? w2_r - 1'b1 : x1c - 1'b1;
    y0c = (y1c == '0) ? h2_r - 1'b1 : y1c - 1'b1;
    oma = ONE - {1'b0, a3_r};
    omb = ONE - {1'b0, b3_r};
  end

  always_comb begin
    wt0c = wt4_r[0];
    v5c  = '0;
    unique case (f4_r)
      FUNC_LOAD: begin
        v5c[0] = VW'(idx4_r);
      end
      FUNC_NEAREST: begin
        v5c[0] = row14_r + VW'(x14_r);
        wt0c   = ONE2;
      end
      default: begin
        v5c[0] = row04_r + VW'(x04_r);
        v5c[1] = row04_r + VW'(x14_r);
        v5c[2] = row14_r + VW'(x04_r);
        v5c[3] = row14_r + VW'(x14_r);
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      qprod[k] = (2*VW+1)'(addr5_r[k]) * (2*VW+1)'(RCP);
      pprod[k] = (2*VW+1)'(q6_r[k]) * (2*VW+1)'(DC);
    end
  end

  always_comb begin
    ent.kind = f7_r;
    ent.wt   = wt7_r;
    ent.rgb  = rgb7_r;
    for (int k = 0; k < 4; k++) begin
      // remainder is below twice the depth, one correction
      ent.addr[k] = ({1'b0, r7_r[k]} >= DC) ? AW'({1'b0, r7_r[k]} - DC) : AW'(r7_r[k]);
    end
  end

  assign q_data = QW'(ent);

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_r   <= in_func;
      idx1_r <= in_index;
      rgb1_r <= in_rgb;
      fs1_r  <= in_fs;
      ft1_r  <= in_ft;
      w1_r   <= size_w;
      h1_r   <= size_h;

      f2_r   <= f1_r;
      idx2_r <= idx1_r;
      rgb2_r <= rgb1_r;
      w2_r   <= w1_r;
      h2_r   <= h1_r;
      ps2_r  <= PS'(w1_r) * PS'(fs1_r) + HALF;
      pt2_r  <= PS'(h1_r) * PS'(ft1_r) + HALF;

      f3_r   <= f2_r;
      idx3_r <= idx2_r;
      rgb3_r <= rgb2_r;
      w3_r   <= w2_r;
      x03_r  <= x0c;
      x13_r  <= x1c;
      y03_r  <= y0c;
      y13_r  <= y1c;
      a3_r   <= ps2_r[F-1:0];
      b3_r   <= pt2_r[F-1:0];

      f4_r    <= f3_r;
      idx4_r  <= idx3_r;
      rgb4_r  <= rgb3_r;
      x04_r   <= x03_r;
      x14_r   <= x13_r;
      row04_r <= VW'(y03_r) * VW'(w3_r);
      row14_r <= VW'(y13_r) * VW'(w3_r);
      wt4_r[0] <= WW'(oma * omb);
      wt4_r[1] <= WW'({1'b0, a3_r} * omb);
      wt4_r[2] <= WW'(oma * {1'b0, b3_r});
      wt4_r[3] <= WW'({1'b0, a3_r} * {1'b0, b3_r});

      f5_r    <= f4_r;
      rgb5_r  <= rgb4_r;
      addr5_r <= v5c;
      wt5_r   <= {wt4_r[3:1], wt0c};

      f6_r    <= f5_r;
      rgb6_r  <= rgb5_r;
      wt6_r   <= wt5_r;
      addr6_r <= addr5_r;
      for (int k = 0; k < 4; k++) begin
        q6_r[k] <= qprod[k][VW +: VW];
      end

      f7_r   <= f6_r;
      rgb7_r <= rgb6_r;
      wt7_r  <= wt6_r;
      for (int k = 0; k < 4; k++) begin
        r7_r[k] <= addr6_r[k] - pprod[k][VW-1:0];
      end
    end
  end
endmodule

### rtl/tsw_back.sv
// tsw_back: drains the op queue, runs texel memory ops and the weighted blend
// depends on tsw_pkg and tsw_ram; results go to the output buffer in the top level
module tsw_back #(
  parameter int TEXEL_DEPTH     = 65536,
  parameter int COORD_FRAC_BITS = 16,
  parameter int QW              = 8,
  parameter int OQ_DEPTH        = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [QW-1:0]               q_head,
  input  logic                        q_empty,
  output logic                        q_pop,
  output logic                        res_push,
  output logic [tsw_pkg::TEXEL_W-1:0] res_data,
  input  logic                        res_pop
);
  import tsw_pkg::*;

  localparam int F  = COORD_FRAC_BITS;
  localparam int AW = (TEXEL_DEPTH > 1) ? $clog2(TEXEL_DEPTH) : 1;
  localparam int WW = 2 * F + 1;
  localparam int AC = 2 * F + 9;
  localparam int CW = $clog2(OQ_DEPTH + 1);
  localparam logic [AC-1:0] RND = AC'(1) << (2 * F - 1);

  typedef struct packed {
    logic [1:0]              kind;
    logic [3:0][AW-1:0]      addr;
    logic [3:0][WW-1:0]      wt;
    logic [TEXEL_W-1:0]      rgb;
  } qent_t;

  qent_t               ent;
  logic [1:0]          cnt_r, cnt_nxt;
  logic [CW-1:0]       cred_r, cred_nxt;
  logic                is_load, is_first, last_op, reserve, go;
  logic                ram_we;
  logic [TEXEL_W-1:0]  rdata;
  logic                rv_r, rf_r, rl_r;
  logic [WW-1:0]       rwt_r;
  logic                pv_r, pf_r, pl_r;
  logic [2:0][AC-1:0]  prod_r, acc_r, acc_nxt;

  assign ent      = qent_t'(q_head);
  assign is_load  = (ent.kind == FUNC_LOAD);
  assign is_first = (cnt_r == '0);
  assign last_op  = (ent.kind == FUNC_BILINEAR) ? (cnt_r == 2'd3) : 1'b1;
  // each sample books an output slot before its first read
  assign reserve  = !q_empty && !is_load && is_first;
  assign go       = !q_empty && (!reserve || cred_r < CW'(OQ_DEPTH));
  assign q_pop    = go && last_op;
  assign ram_we   = go && is_load;

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_pop) begin
      cnt_nxt = '0;
    end else if (go) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    cred_nxt = cred_r;
    if ((go && reserve) && !res_pop) begin
      cred_nxt = cred_r + 1'b1;
    end else if (!(go && reserve) && res_pop) begin
      cred_nxt = cred_r - 1'b1;
    end
  end

  tsw_ram #(
    .WIDTH(TEXEL_W),
    .DEPTH(TEXEL_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ent.addr[cnt_r]),
    .wdata(ent.rgb),
    .rdata(rdata)
  );

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc_nxt[c] = pf_r ? prod_r[c] + RND : acc_r[c] + prod_r[c];
    end
  end

  assign res_push = pv_r && pl_r;
  assign res_data = {acc_nxt[2][2*F +: 8], acc_nxt[1][2*F +: 8], acc_nxt[0][2*F +: 8]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      cred_r <= '0;
      rv_r   <= 1'b0;
      pv_r   <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      cred_r <= cred_nxt;
      rv_r   <= go && !is_load;
      pv_r   <= rv_r;
    end
  end

  always_ff @(posedge clk) begin
    rwt_r <= ent.wt[cnt_r];
    rf_r  <= is_first;
    rl_r  <= last_op;
    pf_r  <= rf_r;
    pl_r  <= rl_r;
    for (int c = 0; c < 3; c++) begin
      prod_r[c] <= AC'(rdata[8*c +: 8]) * AC'(rwt_r);
    end
    if (pv_r) begin
      acc_r <= acc_nxt;
    end
  end

  a_cred_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cred_r <= CW'(OQ_DEPTH))
    else $error("output slot count above buffer depth");

  a_push_booked: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> cred_r != '0)
    else $error("result pushed without a booked slot");

  a_last_to_push: assert property (@(posedge clk) disable iff (!rst_n)
    (go && !is_load && last_op) |-> ##2 res_push)
    else $error("sample result missing after last read");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    go |-> !q_empty)
    else $error("op issued from empty queue");
endmodule

### tb/sv/testbench.sv
// testbench: self-checking bench for texture_sampler_wrap_bilinear_top
// drives load and sample items, predicts colors with its own wrap/blend model
// depends on tsw_pkg and the sampler rtl
module testbench;
  import tsw_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] REG_NONE_A = 2'd2;
  localparam logic [1:0] REG_NONE_B = 2'd3;
  localparam int FRAC = 16;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [31:0] s;
    logic [31:0] t;
  } tex_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [1:0] in_tuser = '0;
  logic [103:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_wdata = '0;

  texture_sampler_wrap_bilinear_top dut (.*);

  tex_item_t pending[$];
  color_t expected_colors[$];
  logic [23:0] texels[int];   // predictor's copy of the store
  bit loaded[int];            // addresses already queued for a load
  logic [8:0] size_w = 9'd1, size_h = 9'd1;
  int errors = 0, samples_seen = 0, loads_sent = 0;
  int gap_left = 0, idle_cycles = 0;
  bit steady = 0, hold_req = 0, finished = 0;
  tex_item_t cur_item;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic longint unsigned eff(logic [8:0] v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic logic [23:0] fetch(longint unsigned x, longint unsigned y,
                                        longint unsigned w);
    return texels[int'((y * w + x) % 65536)];
  endfunction

  // blend or pick texels for one accepted item
  function automatic void sample_color(tex_item_t it);
    longint unsigned w, h, fs, ft, ps, pt, x0, x1, y0, y1, a, b, sum;
    longint unsigned wt[4];
    logic [23:0] tx[4];
    color_t c;
    w = eff(size_w);
    h = eff(size_h);
    fs = it.s[FRAC-1:0];
    ft = it.t[FRAC-1:0];
    ps = w * fs + (1 << (FRAC - 1));
    pt = h * ft + (1 << (FRAC - 1));
    x1 = (ps >> FRAC) % w;
    y1 = (pt >> FRAC) % h;
    if (it.func == FUNC_NEAREST) begin
      c = fetch(x1, y1, w);
    end else begin
      x0 = (x1 == 0) ? w - 1 : x1 - 1;
      y0 = (y1 == 0) ? h - 1 : y1 - 1;
      a = ps & ((1 << FRAC) - 1);
      b = pt & ((1 << FRAC) - 1);
      wt[0] = ((1 << FRAC) - a) * ((1 << FRAC) - b);
      wt[1] = a * ((1 << FRAC) - b);
      wt[2] = ((1 << FRAC) - a) * b;
      wt[3] = a * b;
      tx[0] = fetch(x0, y0, w);
      tx[1] = fetch(x1, y0, w);
      tx[2] = fetch(x0, y1, w);
      tx[3] = fetch(x1, y1, w);
      for (int k = 0; k < 3; k++) begin
        sum = 0;
        for (int j = 0; j < 4; j++) sum += longint'(tx[j][16-8*k +: 8]) * wt[j];
        sum = (sum + (64'd1 << (2 * FRAC - 1))) >> (2 * FRAC);
        c[16-8*k +: 8] = (sum > 255) ? 8'd255 : sum[7:0];
      end
    end
    expected_colors.push_back(c);
  endfunction

  // driver
  always @(posedge clk) begin
    bit busy, nv;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      busy = in_tvalid;
      if (in_tvalid && in_tready) begin
        busy = 0;
        if (cur_item.func == FUNC_LOAD) begin
          texels[int'(cur_item.index)] = {cur_item.red, cur_item.green, cur_item.blue};
          loads_sent++;
        end else if (cur_item.func != FUNC_UNUSED) begin
          sample_color(cur_item);
        end
      end
      nv = busy;
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0) begin
          cur_item = pending.pop_front();
          nv = 1;
          gap_left = pick_gap();
        end
      end
      in_tvalid <= nv;
      in_tuser <= cur_item.func;
      in_tdata <= {cur_item.t, cur_item.s, cur_item.blue, cur_item.green, cur_item.red,
                   cur_item.index};
    end
  end

  // receiver ready, with a long hold-off on request
  always @(posedge clk) begin
    int hold_cnt;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (hold_req && hold_cnt == 0) begin
        hold_cnt = HOLD_CYCLES;
        hold_req = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else if (steady) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) < 70) ||
                      ($urandom_range(0, 99) < 3 ? 1'b0 : 1'b0);
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    color_t got, exp_c;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      samples_seen++;
      if (expected_colors.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        exp_c = expected_colors.pop_front();
        if (got.red != exp_c.blue || got.green != exp_c.green || got.blue != exp_c.red)
        begin
          errors++;
          if (errors <= 10)
            $display("color mismatch: expected r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                     exp_c.red, exp_c.green, exp_c.blue,
                     got.blue, got.green, got.red);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT && !finished) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_load(int idx, logic [23:0] rgb);
    tex_item_t it;
    it = '0;
    it.func = FUNC_LOAD;
    it.index = idx[15:0];
    {it.red, it.green, it.blue} = rgb;
    it.s = $urandom();
    it.t = $urandom();
    loaded[idx & 16'hffff] = 1;
    pending.push_back(it);
  endtask

  task automatic push_sample(logic [1:0] f, logic [31:0] s, logic [31:0] t);
    tex_item_t it;
    it = '0;
    it.func = f;
    it.index = $urandom();
    it.red = $urandom();
    it.green = $urandom();
    it.blue = $urandom();
    it.s = s;
    it.t = t;
    pending.push_back(it);
  endtask

  task automatic wait_idle();
    while (pending.size() > 0 || in_tvalid || expected_colors.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // fill every address the current size can touch
  task automatic cover_texture();
    int span;
    span = int'(eff(size_w) * eff(size_h));
    if (span > 65536) span = 65536;
    for (int a = 0; a < span; a++)
      if (!loaded.exists(a)) push_load(a, $urandom());
  endtask

  task automatic set_size(logic [8:0] w, logic [8:0] h);
    wait_idle();
    size_w = w;
    size_h = h;
    write_reg(REG_TEX_WIDTH, w);
    write_reg(REG_TEX_HEIGHT, h);
  endtask

  task automatic random_items(int n);
    int r, span;
    span = int'(eff(size_w) * eff(size_h));
    if (span > 65536) span = 65536;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 15) push_load($urandom_range(0, span - 1), $urandom());
      else if (r < 55) push_sample(FUNC_NEAREST, $urandom(), $urandom());
      else if (r < 95) push_sample(FUNC_BILINEAR, $urandom(), $urandom());
      else if (r < 97) push_sample(FUNC_UNUSED, $urandom(), $urandom());
      else push_load($urandom(), $urandom());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset size 1x1
    push_load(0, 24'hffffff);
    push_sample(FUNC_NEAREST, 32'h7fffffff, 32'h80000000);
    push_sample(FUNC_BILINEAR, 32'hffff8000, 32'h00000000);
    push_load(16'hffff, 24'h000000);
    push_load(16'haaaa, 24'h55aa55);
    push_load(16'h5555, 24'haa55aa);

    // directed corners on a 4x4 texture
    set_size(9'd4, 9'd4);
    cover_texture();
    push_sample(FUNC_NEAREST, 32'h00000000, 32'h00000000);
    push_sample(FUNC_NEAREST, 32'h0000ffff, 32'hffffffff);
    push_sample(FUNC_NEAREST, 32'h80000000, 32'h7fffffff);
    push_sample(FUNC_BILINEAR, 32'h00000000, 32'h00000000);
    push_sample(FUNC_BILINEAR, 32'h00008000, 32'h00004000);
    push_sample(FUNC_BILINEAR, 32'h0000ffff, 32'hffff0001);
    push_sample(FUNC_BILINEAR, 32'hfffe2000, 32'h12346000);
    push_sample(FUNC_UNUSED, 32'h12345678, 32'h9abcdef0);
    push_sample(FUNC_BILINEAR, 32'h7fffffff, 32'h80000000);
    random_items(80);

    wait_idle();
    write_reg(REG_NONE_A, 9'h1ff);
    write_reg(REG_NONE_B, 9'h0aa);

    set_size(9'd0, 9'd3);
    cover_texture();
    steady = 1;
    random_items(60);
    wait_idle();
    steady = 0;

    set_size(9'd256, 9'd1);
    cover_texture();
    hold_req = 1;
    random_items(80);

    set_size(9'd1, 9'd256);
    cover_texture();
    random_items(60);

    set_size(9'd300, 9'd1);
    cover_texture();
    random_items(60);

    set_size(9'd7, 9'd5);
    cover_texture();
    random_items(60);

    set_size(9'd16, 9'd16);
    cover_texture();
    hold_req = 1;
    random_items(80);

    set_size(9'd3, 9'd0);
    cover_texture();
    random_items(60);

    wait_idle();
    finished = 1;
    $display("covered %0d loads and %0d checked samples over sizes 1x1 to 300x1 and 1x256",
             loads_sent, samples_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
